@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, including while reset is held.
`define ASCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define ASCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ sv/ascd_pkg.sv @@
// Package with the formats, register indexes and shaping coefficients of the converter.
`timescale 1ns / 1ps
package ascd_pkg;

   localparam int ASCD_FRACTION_BITS = 16;
   localparam int COEF_BITS          = 14;
   localparam int COEF_WIDTH         = 17;
   localparam int NUM_TAPS           = 5;

   localparam logic [1:0] FMT_INT16 = 2'd0;
   localparam logic [1:0] FMT_INT24 = 2'd1;
   localparam logic [1:0] FMT_FLOAT = 2'd2;

   localparam logic [1:0] DITHER_NONE   = 2'd0;
   localparam logic [1:0] DITHER_RECT   = 2'd1;
   localparam logic [1:0] DITHER_TRI    = 2'd2;
   localparam logic [1:0] DITHER_SHAPED = 2'd3;

   localparam logic [1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_DEST_FORMAT   = 2'd1;
   localparam logic [1:0] CSR_DITHER_MODE   = 2'd2;

   typedef struct packed {
      logic [1:0] source_format;
      logic [1:0] dest_format;
      logic [1:0] dither_mode;
   } cfg_type;

   // Lipshitz shaping filter in Q14.
   function automatic logic signed [COEF_WIDTH-1:0] shape_coef(input int k);
      logic signed [COEF_WIDTH-1:0] c;
      case (k)
         0:       c = 17'sd33309;
         1:       c = -17'sd35471;
         2:       c = 17'sd32096;
         3:       c = -17'sd26051;
         default: c = 17'sd10075;
      endcase
      return c;
   endfunction

endpackage

@@ sv/ascd_fifo.sv @@
// Two-entry queue used between the front and back parts and on the result side.
`timescale 1ns / 1ps
module ascd_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/ascd_front.sv @@
// Front part: classifies an item and forms either its final word or its fixed-point value.
`timescale 1ns / 1ps
module ascd_front import ascd_pkg::*; #(
   parameter int FRACTION_BITS = ASCD_FRACTION_BITS,
   parameter int W             = FRACTION_BITS + 28
) (
   input  cfg_type                cfg,
   input  logic [31:0]            sample_in,
   output logic                   narrow,
   output logic [31:0]            word,
   output logic signed [W-1:0]    x
);

   logic [1:0] sf, df;

   function automatic logic [31:0] to_float(input logic signed [23:0] v, input logic is24);
      logic [23:0] m;
      logic [4:0]  p;
      logic [7:0]  ex;
      logic [23:0] sh;
      m = v[23] ? 24'(-v) : 24'(v);
      p = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (m[i]) p = 5'(i);
      end
      ex = {3'b000, p} + (is24 ? 8'd104 : 8'd112);
      sh = m << (5'd23 - p);
      return (m == 24'd0) ? 32'd0 : {v[23], ex, sh[22:0]};
   endfunction

   always_comb begin
      logic [7:0]   e;
      logic [22:0]  man;
      logic [23:0]  v24;
      logic [W-1:0] mag;
      logic [63:0]  ext;
      logic [23:0]  qm;
      logic         up;
      int           dpos;
      int           sh_i;
      sf     = (cfg.source_format == 2'd3) ? FMT_FLOAT : cfg.source_format;
      df     = (cfg.dest_format == 2'd3) ? FMT_FLOAT : cfg.dest_format;
      e      = sample_in[30:23];
      man    = sample_in[22:0];
      v24    = {(e != 8'd0), man};
      dpos   = (df == FMT_INT16) ? 15 : 23;
      sh_i   = ((e == 8'd0) ? 1 : int'(e)) - 150 + dpos + FRACTION_BITS;
      ext    = 64'd0;
      qm     = 24'd0;
      up     = 1'b0;
      mag    = '0;
      narrow = 1'b0;
      word   = sample_in;
      x      = '0;
      if (sf == df) begin
         if (sf == FMT_INT16) word = 32'(signed'(sample_in[15:0]));
         else if (sf == FMT_INT24) word = 32'(signed'(sample_in[23:0]));
      end else if (df == FMT_FLOAT) begin
         word = (sf == FMT_INT16) ? to_float(24'(signed'(sample_in[15:0])), 1'b0)
                                  : to_float(signed'(sample_in[23:0]), 1'b1);
      end else if (sf == FMT_INT16) begin
         word = {{8{sample_in[15]}}, sample_in[15:0], 8'd0};
      end else begin
         narrow = 1'b1;
         if (sf == FMT_INT24) begin
            x = W'(signed'(sample_in[23:0])) <<< (FRACTION_BITS - 8);
         end else begin
            // Float input is clamped to [-1, 1]; NaN counts as zero.
            if (e == 8'hFF && man != 23'd0) begin
               mag = '0;
            end else if (e >= 8'd127) begin
               mag = W'(1) << (dpos + FRACTION_BITS);
            end else if (sh_i >= 0) begin
               mag = W'(v24) << sh_i;
            end else begin
               ext = {v24, 40'd0} >> (-sh_i);
               qm  = ext[63:40];
               up  = ext[39] && ((|ext[38:0]) || qm[0]);
               mag = W'(qm) + W'(up);
            end
            x = sample_in[31] ? -signed'(mag) : signed'(mag);
         end
      end
   end

endmodule

@@ sv/ascd_back.sv @@
// Back part: dither, noise shaping, rounding and saturation; one item at a time.
`timescale 1ns / 1ps
module ascd_back import ascd_pkg::*; #(
   parameter int FRACTION_BITS = ASCD_FRACTION_BITS,
   parameter int W             = FRACTION_BITS + 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 head_valid,
   input  logic                 head_narrow,
   input  logic [31:0]          head_word,
   input  logic signed [W-1:0]  head_x,
   input  logic [15:0]          head_noise_a,
   input  logic [15:0]          head_noise_b,
   input  logic                 head_block_start,
   input  logic                 out_full,
   output logic                 head_pop,
   output logic                 out_push,
   output logic [31:0]          out_word
);

   localparam int F  = FRACTION_BITS;
   localparam int EW = F + 2;
   localparam int PW = COEF_WIDTH + EW;
   localparam int AW = PW + 3;

   logic signed [EW-1:0] tap_ff [NUM_TAPS];
   logic signed [EW-1:0] tap_in [NUM_TAPS];
   logic signed [F-1:0]  prev_ff, prev_in;

   logic                 a_valid_ff, a_valid_in;
   logic                 a_narrow_ff, a_clr_ff;
   logic [31:0]          a_word_ff;
   logic signed [W-1:0]  a_x_ff;
   logic signed [F-1:0]  a_na_ff, a_nb_ff, a_prev_ff;
   logic signed [PW-1:0] a_p_ff [NUM_TAPS];

   logic                 take, clr;
   logic signed [F-1:0]  na, nb;

   function automatic logic signed [F-1:0] noise_value(input logic [15:0] n);
      logic [F-1:0] nv;
      nv = F'({n, 8'd0} >> (24 - F));
      // Subtracting half of the range is a flip of the top bit.
      return signed'({~nv[F-1], nv[F-2:0]});
   endfunction

   assign take     = head_valid && !a_valid_ff && !out_full;
   assign head_pop = take;
   assign clr      = head_block_start && head_narrow && cfg.dither_mode[1];
   assign na       = noise_value(head_noise_a);
   assign nb       = noise_value(head_noise_b);
   assign a_valid_in = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Capture step: register the item and the products of the shaping filter.
   always_ff @(posedge clock) begin
      if (take) begin
         a_narrow_ff <= head_narrow;
         a_clr_ff    <= clr;
         a_word_ff   <= head_word;
         a_x_ff      <= head_x;
         a_na_ff     <= na;
         a_nb_ff     <= nb;
         a_prev_ff   <= clr ? '0 : prev_ff;
         for (int k = 0; k < NUM_TAPS; k++) begin
            a_p_ff[k] <= clr ? '0 : PW'(shape_coef(k)) * PW'(tap_ff[k]);
         end
      end
   end

   // Finish step: finish the value and update the dither state.
   always_comb begin
      logic signed [AW-1:0] acc;
      logic signed [AW-1:0] acc_q;
      logic                 acc_up;
      logic signed [W-1:0]  xe, y, qf, qr, qs, hi, lo;
      logic                 y_up;
      logic signed [EW-1:0] err;
      acc = '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
         acc = acc + AW'(a_p_ff[k]);
      end
      acc_q  = acc >>> COEF_BITS;
      acc_up = acc[COEF_BITS-1] && ((|acc[COEF_BITS-2:0]) || acc_q[0]);
      xe     = a_x_ff + W'(acc_q) + W'({1'b0, acc_up});
      unique case (cfg.dither_mode)
         DITHER_NONE:   y = a_x_ff;
         DITHER_RECT:   y = a_x_ff - W'(a_na_ff);
         DITHER_TRI:    y = a_x_ff + W'(a_na_ff) - W'(a_prev_ff);
         DITHER_SHAPED: y = W'(a_na_ff) + W'(a_nb_ff) + xe;
         default:       y = a_x_ff;
      endcase
      qf   = y >>> F;
      y_up = y[F-1] && ((|y[F-2:0]) || qf[0]);
      qr   = qf + W'({1'b0, y_up});
      err  = EW'(xe - (qr <<< F));
      hi   = (cfg.dest_format == FMT_INT16) ? W'(32767) : W'(8388607);
      lo   = (cfg.dest_format == FMT_INT16) ? -W'(32768) : -W'(8388608);
      if (qr > hi) qs = hi;
      else if (qr < lo) qs = lo;
      else qs = qr;
      out_push = a_valid_ff;
      out_word = a_narrow_ff ? 32'(qs) : a_word_ff;

      prev_in = prev_ff;
      for (int k = 0; k < NUM_TAPS; k++) begin
         tap_in[k] = tap_ff[k];
      end
      if (a_valid_ff && a_narrow_ff) begin
         if (a_clr_ff) begin
            prev_in = '0;
            for (int k = 0; k < NUM_TAPS; k++) begin
               tap_in[k] = '0;
            end
         end
         if (cfg.dither_mode == DITHER_TRI) begin
            prev_in = a_na_ff;
         end else if (cfg.dither_mode == DITHER_SHAPED) begin
            tap_in[0] = err;
            for (int k = 1; k < NUM_TAPS; k++) begin
               tap_in[k] = a_clr_ff ? '0 : tap_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         for (int k = 0; k < NUM_TAPS; k++) begin
            tap_ff[k] <= '0;
         end
      end else begin
         prev_ff <= prev_in;
         for (int k = 0; k < NUM_TAPS; k++) begin
            tap_ff[k] <= tap_in[k];
         end
      end
   end

endmodule

@@ sv/audio_sample_convert_dither.sv @@
// Top level of the audio sample converter with dither and noise shaping.
//
// Input side behaves as a queue: an item (sample, two noise words, block start
// flag) is taken when req_push is high and req_full is low.
// Result side behaves as a queue too: rsp_sample_out holds the oldest result
// while rsp_empty is low, and it is removed when rsp_pop is high.
// Configuration writes go through csr_valid/csr_ready with a register index
// and two data bits; csr_ready is always high. Write only while idle.
// A front stage classifies each item and forms its final word or its
// fixed-point value; a two-entry queue decouples it from the back stage,
// which takes no new item while the last one is still being finished,
// because the shaped error of one sample feeds the next sample's filter.
// A stalled receiver fills the two-entry result queue and then the input
// queue, after which req_full rises; nothing is lost.
// Reset empties both queues, clears the dither state and loads the registers
// with float source, int16 destination and noise-shaped dither.
`timescale 1ns / 1ps
module audio_sample_convert_dither import ascd_pkg::*; #(
   parameter int FRACTION_BITS = ASCD_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_sample_in,
   input  logic [15:0] req_noise_a,
   input  logic [15:0] req_noise_b,
   input  logic        req_block_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_sample_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   localparam int W  = FRACTION_BITS + 28;
   localparam int QW = 1 + 32 + W + 16 + 16 + 1;

   cfg_type cfg_ff, cfg_in;

   logic                f_narrow;
   logic [31:0]         f_word;
   logic signed [W-1:0] f_x;
   logic [QW-1:0]       q_push_data, q_head;
   logic                q_full, q_empty, q_pop;
   logic                b_out_push, o_full;
   logic [31:0]         b_out_word;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_FORMAT: cfg_in.source_format = csr_data;
            CSR_DEST_FORMAT:   cfg_in.dest_format   = csr_data;
            CSR_DITHER_MODE:   cfg_in.dither_mode   = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format <= FMT_FLOAT;
         cfg_ff.dest_format   <= FMT_INT16;
         cfg_ff.dither_mode   <= DITHER_SHAPED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ascd_front #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_front (
      .cfg       (cfg_ff),
      .sample_in (req_sample_in),
      .narrow    (f_narrow),
      .word      (f_word),
      .x         (f_x)
   );

   assign q_push_data = {f_narrow, f_word, f_x, req_noise_a, req_noise_b, req_block_start};
   assign req_full    = q_full;

   ascd_fifo #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ascd_back #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (!q_empty),
      .head_narrow      (q_head[QW-1]),
      .head_word        (q_head[QW-2 -: 32]),
      .head_x           (signed'(q_head[W+32:33])),
      .head_noise_a     (q_head[32:17]),
      .head_noise_b     (q_head[16:1]),
      .head_block_start (q_head[0]),
      .out_full         (o_full),
      .head_pop         (q_pop),
      .out_push         (b_out_push),
      .out_word         (b_out_word)
   );

   ascd_fifo #(.WIDTH(32)) u_result (
      .clock     (clock),
      .reset     (reset),
      .push      (b_out_push),
      .push_data (b_out_word),
      .pop       (rsp_pop),
      .pop_data  (rsp_sample_out),
      .full      (o_full),
      .empty     (rsp_empty)
   );

endmodule

@@ sv/ascd_checker.sv @@
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ascd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [31:0] req_sample_in,
   input logic [15:0] req_noise_a,
   input logic [15:0] req_noise_b,
   input logic        req_block_start,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_sample_out,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [1:0]  csr_data
);

   // After reset no result is waiting and the input side has room.
   `ASCD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "result after reset")
   `ASCD_ASSERT_ALWAYS(a_reset_room, clock, reset |=> !req_full, "input full after reset")
   // Configuration writes are never held off.
   `ASCD_ASSERT(a_csr_ready, clock, reset, csr_ready, "configuration port not ready")
   // A waiting result stays put until it is taken.
   `ASCD_ASSERT(a_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_sample_out)),
      "waiting result changed")

endmodule

bind audio_sample_convert_dither ascd_checker u_chk (.*);
